>>> sv/cdm_pkg.sv
// Shared types and constants of the Chebyshev distance map.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package cdm_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;
    localparam int COORD_W  = 6;
    localparam int AREA_W   = 7;
    localparam int DIST_W   = 6;
    localparam int KIND_W   = 2;
    localparam int ADDR_W   = 2 * COORD_W;
    localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 7;

    // cell kinds as stored in the grid
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_O     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_X     = 2'd2;

    // item commands
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // register indexes of the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_PLAYER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd2;

    // player codes
    localparam logic [1:0] PLAYER_ONE = 2'd1;
    localparam logic [1:0] PLAYER_TWO = 2'd2;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_SCAN,
        OP_ZERO
    } cdm_op_t;

    typedef struct packed {
        cdm_op_t             op;
        logic [COORD_W-1:0]  row;
        logic [COORD_W-1:0]  col;
        logic [KIND_W-1:0]   kind;
        logic [KIND_W-1:0]   target;
        logic [COORD_W-1:0]  last_row;
        logic [COORD_W-1:0]  last_col;
    } cdm_entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } cdm_q_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } cdm_state_t;

endpackage

>>> sv/cdm_in_if.sv
// Input item channel of the distance map: valid/ready plus item fields.
// Depends on cdm_pkg for field widths.
`timescale 1ns / 1ps

interface cdm_in_if;
    logic                        valid;
    logic                        ready;
    logic                        cmd;
    logic [cdm_pkg::COORD_W-1:0] row;
    logic [cdm_pkg::COORD_W-1:0] col;
    logic [cdm_pkg::KIND_W-1:0]  cell_kind;

    modport source (output valid, output cmd, output row, output col, output cell_kind,
                    input ready);
    modport sink   (input valid, input cmd, input row, input col, input cell_kind,
                    output ready);
endinterface

>>> sv/cdm_out_if.sv
// Result channel of the distance map: valid/ready plus the distance.
// Depends on cdm_pkg for the field width.
`timescale 1ns / 1ps

interface cdm_out_if;
    logic                       valid;
    logic                       ready;
    logic [cdm_pkg::DIST_W-1:0] distance;

    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

>>> sv/cdm_cfg_if.sv
// Configuration write channel: valid/ready, register index and write data.
// Depends on cdm_pkg for widths.
`timescale 1ns / 1ps

interface cdm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [cdm_pkg::CFG_IDX_W-1:0]  index;
    logic [cdm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/chebyshev_distance_map.sv
// Top level of the Chebyshev distance map: front end, queue and back end.
// Depends on cdm_pkg, the three channel interfaces, cdm_front, cdm_queue, cdm_back.
`timescale 1ns / 1ps

// The block keeps a 64 by 64 grid of 2-bit cells (empty, o, x) in a memory with
// a write port and a registered read port. A write item stores one cell. A query
// item on an empty cell inside the active area scans the active area (grid_rows
// by grid_cols, clamped to 64 by 64) one cell per cycle through the memory read
// port and answers the smallest Chebyshev distance to a target cell (x for
// player 1, o for player 2), or 0 if none exists. A query on an occupied cell,
// outside the area or with an invalid player skips the scan. The scan of the
// back end sets the rate: it handles one item at a time, while the front end
// keeps accepting items into a two-entry queue and a finished result waits in
// the output register. Configuration writes are taken at any time but must only
// be issued while the block is idle. Grid cells have no reset value; the whole
// active area must be written before it is queried.

module chebyshev_distance_map (
    input  logic      clk,
    input  logic      rst_n,
    cdm_cfg_if.sink   cfg,
    cdm_in_if.sink    item,
    cdm_out_if.source result
);

    cdm_pkg::cdm_entry_t    push_entry;
    cdm_pkg::cdm_entry_t    head;
    cdm_pkg::cdm_q_status_t q_status;
    logic                   push;
    logic                   pop;

    // intake and classification against the current configuration
    cdm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    // decouples intake from the long scan
    cdm_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (q_status)
    );

    // grid memory, scan and result register
    cdm_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .result   (result)
    );

    // queue cannot be full and empty at once
    a_q_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue reports full and empty");

    // back end only takes an entry that is there
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("pop from empty queue");

    // a write transfer never produces a result
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && (head.op == cdm_pkg::OP_WRITE) && !result.valid) |=> !result.valid)
        else $error("result after a cell write");

endmodule

>>> sv/cdm_front.sv
// Front end: configuration registers, item intake and classification.
// Depends on cdm_pkg, cdm_in_if and cdm_cfg_if.
`timescale 1ns / 1ps

module cdm_front (
    input  logic                   clk,
    input  logic                   rst_n,
    cdm_cfg_if.sink                cfg,
    cdm_in_if.sink                 item,
    input  cdm_pkg::cdm_q_status_t q_status,
    output logic                   push,
    output cdm_pkg::cdm_entry_t    push_entry
);

    logic [1:0]                    player_reg;
    logic [cdm_pkg::AREA_W-1:0]    rows_reg;
    logic [cdm_pkg::AREA_W-1:0]    cols_reg;
    logic [cdm_pkg::AREA_W-1:0]    rows_eff;
    logic [cdm_pkg::AREA_W-1:0]    cols_eff;
    logic                          player_ok;
    logic                          in_area;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            player_reg <= cdm_pkg::PLAYER_ONE;
            rows_reg   <= cdm_pkg::AREA_W'(cdm_pkg::MAX_ROWS);
            cols_reg   <= cdm_pkg::AREA_W'(cdm_pkg::MAX_COLS);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                cdm_pkg::CFG_PLAYER: player_reg <= cfg.data[1:0];
                cdm_pkg::CFG_ROWS:   rows_reg   <= cfg.data;
                cdm_pkg::CFG_COLS:   cols_reg   <= cfg.data;
                default:             ;
            endcase
        end
    end

    // active area clamped to storage
    assign rows_eff = (rows_reg > cdm_pkg::AREA_W'(cdm_pkg::MAX_ROWS))
                    ? cdm_pkg::AREA_W'(cdm_pkg::MAX_ROWS) : rows_reg;
    assign cols_eff = (cols_reg > cdm_pkg::AREA_W'(cdm_pkg::MAX_COLS))
                    ? cdm_pkg::AREA_W'(cdm_pkg::MAX_COLS) : cols_reg;

    assign player_ok = (player_reg == cdm_pkg::PLAYER_ONE) ||
                       (player_reg == cdm_pkg::PLAYER_TWO);
    assign in_area   = ({1'b0, item.row} < rows_eff) && ({1'b0, item.col} < cols_eff);

    assign item.ready = !q_status.full;
    assign push       = item.valid && !q_status.full;

    always_comb
    begin
        push_entry.row      = item.row;
        push_entry.col      = item.col;
        push_entry.kind     = item.cell_kind;
        push_entry.target   = (player_reg == cdm_pkg::PLAYER_ONE)
                            ? cdm_pkg::KIND_X : cdm_pkg::KIND_O;
        push_entry.last_row = cdm_pkg::COORD_W'(rows_eff - 1'b1);
        push_entry.last_col = cdm_pkg::COORD_W'(cols_eff - 1'b1);
        if (item.cmd == cdm_pkg::CMD_WRITE)
            push_entry.op = cdm_pkg::OP_WRITE;
        else if (player_ok && in_area)
            push_entry.op = cdm_pkg::OP_SCAN;
        else
            push_entry.op = cdm_pkg::OP_ZERO;
    end

endmodule

>>> sv/cdm_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on cdm_pkg.
`timescale 1ns / 1ps

module cdm_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  cdm_pkg::cdm_entry_t    push_entry,
    input  logic                   pop,
    output cdm_pkg::cdm_entry_t    head,
    output cdm_pkg::cdm_q_status_t status
);

    cdm_pkg::cdm_entry_t entry_reg [2];
    logic                wr_ptr_reg;
    logic                rd_ptr_reg;
    logic [1:0]          count_reg;
    logic [1:0]          count_next;
    logic                do_push;
    logic                do_pop;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 2'd1;
        else if (do_pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

>>> sv/cdm_back.sv
// Back end: grid memory, scan sequencer, running minimum and result register.
// Depends on cdm_pkg and cdm_out_if.
`timescale 1ns / 1ps

module cdm_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  cdm_pkg::cdm_entry_t    head,
    input  cdm_pkg::cdm_q_status_t q_status,
    output logic                   pop,
    cdm_out_if.source              result
);

    logic [cdm_pkg::KIND_W-1:0] grid_mem [cdm_pkg::MEM_DEPTH];
    logic [cdm_pkg::KIND_W-1:0] rd_data_reg;
    logic [cdm_pkg::ADDR_W-1:0] rd_addr;
    logic                       wr_en;

    cdm_pkg::cdm_state_t        state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [cdm_pkg::DIST_W-1:0] out_dist_reg, out_dist_next;
    logic                       pipe_vld_reg, pipe_vld_next;

    logic [cdm_pkg::COORD_W-1:0] pipe_r_reg, pipe_r_next;
    logic [cdm_pkg::COORD_W-1:0] pipe_c_reg, pipe_c_next;
    logic [cdm_pkg::COORD_W-1:0] scan_r_reg, scan_r_next;
    logic [cdm_pkg::COORD_W-1:0] scan_c_reg, scan_c_next;
    logic [cdm_pkg::COORD_W-1:0] qr_reg, qr_next;
    logic [cdm_pkg::COORD_W-1:0] qc_reg, qc_next;
    logic [cdm_pkg::COORD_W-1:0] last_r_reg, last_r_next;
    logic [cdm_pkg::COORD_W-1:0] last_c_reg, last_c_next;
    logic [cdm_pkg::KIND_W-1:0]  target_reg, target_next;
    logic [cdm_pkg::DIST_W-1:0]  best_reg, best_next;
    logic                        found_reg, found_next;

    logic [cdm_pkg::COORD_W-1:0] dr;
    logic [cdm_pkg::COORD_W-1:0] dc;
    logic [cdm_pkg::DIST_W-1:0]  cell_dist;

    // grid storage, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
            grid_mem[{head.row, head.col}] <= head.kind;
        rd_data_reg <= grid_mem[rd_addr];
    end

    assign dr        = (pipe_r_reg >= qr_reg) ? (pipe_r_reg - qr_reg) : (qr_reg - pipe_r_reg);
    assign dc        = (pipe_c_reg >= qc_reg) ? (pipe_c_reg - qc_reg) : (qc_reg - pipe_c_reg);
    assign cell_dist = (dr > dc) ? dr : dc;

    assign result.valid    = out_valid_reg;
    assign result.distance = out_dist_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !result.ready;
        out_dist_next  = out_dist_reg;
        pipe_vld_next  = 1'b0;
        pipe_r_next    = scan_r_reg;
        pipe_c_next    = scan_c_reg;
        scan_r_next    = scan_r_reg;
        scan_c_next    = scan_c_reg;
        qr_next        = qr_reg;
        qc_next        = qc_reg;
        last_r_next    = last_r_reg;
        last_c_next    = last_c_reg;
        target_next    = target_reg;
        best_next      = best_reg;
        found_next     = found_reg;
        pop            = 1'b0;
        wr_en          = 1'b0;
        rd_addr        = {scan_r_reg, scan_c_reg};

        // running minimum over the cell read last cycle
        if (pipe_vld_reg && (rd_data_reg == target_reg))
        begin
            if (!found_reg || (cell_dist < best_reg))
            begin
                best_next  = cell_dist;
                found_next = 1'b1;
            end
        end

        case (state_reg)
            cdm_pkg::ST_IDLE:
            begin
                rd_addr = {head.row, head.col};
                if (!q_status.empty)
                begin
                    pop         = 1'b1;
                    qr_next     = head.row;
                    qc_next     = head.col;
                    last_r_next = head.last_row;
                    last_c_next = head.last_col;
                    target_next = head.target;
                    found_next  = 1'b0;
                    case (head.op)
                        cdm_pkg::OP_WRITE: wr_en      = 1'b1;
                        cdm_pkg::OP_SCAN:  state_next = cdm_pkg::ST_CHECK;
                        default:           state_next = cdm_pkg::ST_RESULT;
                    endcase
                end
            end
            cdm_pkg::ST_CHECK:
            begin
                if ((rd_data_reg == cdm_pkg::KIND_O) || (rd_data_reg == cdm_pkg::KIND_X))
                    state_next = cdm_pkg::ST_RESULT;
                else
                begin
                    scan_r_next = '0;
                    scan_c_next = '0;
                    state_next  = cdm_pkg::ST_SCAN;
                end
            end
            cdm_pkg::ST_SCAN:
            begin
                pipe_vld_next = 1'b1;
                if (scan_c_reg == last_c_reg)
                begin
                    scan_c_next = '0;
                    scan_r_next = scan_r_reg + 1'b1;
                    if (scan_r_reg == last_r_reg)
                        state_next = cdm_pkg::ST_DRAIN;
                end
                else
                    scan_c_next = scan_c_reg + 1'b1;
            end
            cdm_pkg::ST_DRAIN:
            begin
                state_next = cdm_pkg::ST_RESULT;
            end
            cdm_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dist_next  = found_reg ? best_reg : '0;
                    state_next     = cdm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cdm_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cdm_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            pipe_vld_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pipe_vld_reg  <= pipe_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_dist_reg <= out_dist_next;
        pipe_r_reg   <= pipe_r_next;
        pipe_c_reg   <= pipe_c_next;
        scan_r_reg   <= scan_r_next;
        scan_c_reg   <= scan_c_next;
        qr_reg       <= qr_next;
        qc_reg       <= qc_next;
        last_r_reg   <= last_r_next;
        last_c_reg   <= last_c_next;
        target_reg   <= target_next;
        best_reg     <= best_next;
        found_reg    <= found_next;
    end

endmodule
